// ----- hw/rtl/bpd_pkg.sv -----
package bpd_pkg;

    // default sizes of the mesh and the arithmetic
    localparam int GRID_W_DEF    = 64;
    localparam int GRID_H_DEF    = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_WIDTH_DEF = 40;

    // fixed field widths
    localparam int POS_W     = 16;
    localparam int IDX_IN_W  = 12;
    localparam int OUT_SUM_W = 40;
    localparam int CELL_W    = 6;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_DOWN   = 1'b1;
    localparam logic [CELL_W-1:0]    CELLS_RESET      = 6'd63;

    // request kinds
    localparam logic ACT_DEPOSIT = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    // corner order: base, right, below, below right
    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic       clear_en;
        logic       accept_dep;
        logic       accept_rd;
        logic       scale;
        logic       rmw;
        logic [1:0] corner;
        logic       out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } dp_status_t;

endpackage

// ----- hw/rtl/bpd_ctrl.sv -----
module bpd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                action,
    output logic                in_stall,
    output bpd_pkg::dp_cmd_t    cmd,
    input  bpd_pkg::dp_status_t status
);
    import bpd_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCALE,
        ST_RMW,
        ST_READ
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] corner_reg;
    logic [1:0] corner_next;
    logic       accept;

    // requests are taken only when idle
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        corner_next    = corner_reg;
        cmd            = '0;
        cmd.corner     = corner_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_READ)
                    begin
                        cmd.accept_rd = 1'b1;
                        state_next    = ST_READ;
                    end
                    else
                    begin
                        cmd.accept_dep = 1'b1;
                        state_next     = ST_SCALE;
                    end
                end
            end
            ST_SCALE:
            begin
                cmd.scale   = 1'b1;
                corner_next = CORNER_FIRST;
                state_next  = ST_RMW;
            end
            ST_RMW:
            begin
                cmd.rmw = 1'b1;
                if (corner_reg == CORNER_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    corner_next = corner_reg + 2'd1;
                end
            end
            ST_READ:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and corner counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            corner_reg <= CORNER_FIRST;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

endmodule

// ----- hw/rtl/bpd_dp.sv -----
module bpd_dp #(
    parameter int GRID_W    = bpd_pkg::GRID_W_DEF,
    parameter int GRID_H    = bpd_pkg::GRID_H_DEF,
    parameter int FRAC_BITS = bpd_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = bpd_pkg::ACC_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpd_pkg::CELL_W-1:0]    cfg_data,
    input  logic [bpd_pkg::POS_W-1:0]     pos_x,
    input  logic [bpd_pkg::POS_W-1:0]     pos_y,
    input  logic [bpd_pkg::IDX_IN_W-1:0]  node_index,
    input  logic                          clear_after_read,
    input  bpd_pkg::dp_cmd_t              cmd,
    output bpd_pkg::dp_status_t           status,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [bpd_pkg::OUT_SUM_W-1:0] node_sum,
    output logic                          saturated
);
    import bpd_pkg::*;

    localparam int NODES  = GRID_W * GRID_H;
    localparam int IDX_W  = $clog2(NODES);
    localparam int WORD_W = ACC_WIDTH + 1;
    localparam int SX_W   = POS_W + CELL_W;
    localparam int FAC_W  = POS_W + 1;
    localparam int PROD_W = 2 * FAC_W;
    localparam int SH     = 2 * POS_W - FRAC_BITS;
    localparam int WGT_W  = FRAC_BITS + 1;
    localparam int SUM_W  = ((ACC_WIDTH > WGT_W) ? ACC_WIDTH : WGT_W) + 1;
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

    // zero counts as one cell, too many cells clamp to the grid
    function automatic logic [CELL_W-1:0] eff_cells(input logic [CELL_W-1:0] c,
                                                    input int limit);
        logic [CELL_W-1:0] r;
        r = (c == '0) ? CELL_W'(1) : c;
        if (int'(r) > limit)
        begin
            r = CELL_W'(limit);
        end
        return r;
    endfunction

    // address offset of a cell corner from its base node
    function automatic logic [IDX_W-1:0] corner_off(input logic [1:0] k);
        logic [IDX_W-1:0] r;
        case (k)
            2'd0:    r = '0;
            2'd1:    r = IDX_W'(1);
            2'd2:    r = IDX_W'(GRID_W);
            2'd3:    r = IDX_W'(GRID_W + 1);
            default: r = '0;
        endcase
        return r;
    endfunction

    logic [CELL_W-1:0]    cells_across_reg;
    logic [CELL_W-1:0]    cells_down_reg;
    logic [CELL_W-1:0]    cx;
    logic [CELL_W-1:0]    cy;
    logic [IDX_W-1:0]     clr_cnt_reg;
    logic                 out_valid_reg;
    logic [SX_W-1:0]      sx_reg;
    logic [SX_W-1:0]      sy_reg;
    logic [IDX_W-1:0]     base_reg;
    logic [WGT_W-1:0]     w_reg [4];
    logic [IDX_W-1:0]     node_addr_reg;
    logic                 clr_req_reg;
    logic                 oor_reg;
    logic [OUT_SUM_W-1:0] node_sum_reg;
    logic                 sat_reg;
    logic [WORD_W-1:0]    mesh_reg [NODES];
    logic [WORD_W-1:0]    rd_data_reg;

    logic                 in_range;
    logic [CELL_W-1:0]    ci;
    logic [CELL_W-1:0]    cj;
    logic [IDX_W-1:0]     base_comb;
    logic [FAC_W-1:0]     hx;
    logic [FAC_W-1:0]     hy;
    logic [FAC_W-1:0]     gx;
    logic [FAC_W-1:0]     gy;
    logic [PROD_W-1:0]    prod [4];
    logic [ACC_WIDTH-1:0] old_sum;
    logic                 old_flag;
    logic [SUM_W-1:0]     add_sum;
    logic                 hit_max;
    logic [WORD_W-1:0]    new_word;
    logic [63:0]          sum_wide;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [WORD_W-1:0]    wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;

    assign cx = eff_cells(cells_across_reg, GRID_W - 1);
    assign cy = eff_cells(cells_down_reg, GRID_H - 1);

    assign in_range = (32'(node_index) < 32'(NODES));

    // cell index, kept inside the last cell
    always_comb
    begin
        ci = sx_reg[SX_W-1:POS_W];
        cj = sy_reg[SX_W-1:POS_W];
        if (ci > cx - CELL_W'(1))
        begin
            ci = cx - CELL_W'(1);
        end
        if (cj > cy - CELL_W'(1))
        begin
            cj = cy - CELL_W'(1);
        end
        base_comb = IDX_W'(32'(cj) * GRID_W + 32'(ci));
    end

    // bilinear weights, each product exact then truncated
    assign hx = {1'b0, sx_reg[POS_W-1:0]};
    assign hy = {1'b0, sy_reg[POS_W-1:0]};
    assign gx = (FAC_W'(1) << POS_W) - hx;
    assign gy = (FAC_W'(1) << POS_W) - hy;
    assign prod[0] = PROD_W'(gx) * PROD_W'(gy);
    assign prod[1] = PROD_W'(hx) * PROD_W'(gy);
    assign prod[2] = PROD_W'(gx) * PROD_W'(hy);
    assign prod[3] = PROD_W'(hx) * PROD_W'(hy);

    // saturating add of one corner weight
    always_comb
    begin
        old_sum  = rd_data_reg[ACC_WIDTH-1:0];
        old_flag = rd_data_reg[ACC_WIDTH];
        add_sum  = SUM_W'(old_sum) + SUM_W'(w_reg[cmd.corner]);
        hit_max  = (add_sum >= SUM_W'(ACC_MAX));
        new_word = {old_flag | hit_max, hit_max ? ACC_MAX : add_sum[ACC_WIDTH-1:0]};
        sum_wide = 64'(old_sum);
    end

    // mesh port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = base_reg + corner_off(cmd.corner);
        wr_data = new_word;
        if (cmd.clear_en)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else if (cmd.rmw)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.out_load && clr_req_reg && !oor_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = node_addr_reg;
            wr_data = '0;
        end

        rd_en   = 1'b0;
        rd_addr = IDX_W'(node_index);
        if (cmd.accept_rd)
        begin
            rd_en = in_range;
        end
        else if (cmd.scale)
        begin
            rd_en   = 1'b1;
            rd_addr = base_comb;
        end
        else if (cmd.rmw && (cmd.corner != CORNER_LAST))
        begin
            rd_en   = 1'b1;
            rd_addr = base_reg + corner_off(cmd.corner + 2'd1);
        end
    end

    // mesh memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mesh_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mesh_reg[rd_addr];
        end
    end

    // configuration, clear sweep and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_across_reg <= CELLS_RESET;
            cells_down_reg   <= CELLS_RESET;
            clr_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_CELLS_ACROSS: cells_across_reg <= cfg_data;
                    REG_CELLS_DOWN:   cells_down_reg   <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.clear_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept_dep)
        begin
            sx_reg <= SX_W'(pos_x) * SX_W'(cx);
            sy_reg <= SX_W'(pos_y) * SX_W'(cy);
        end
        if (cmd.accept_rd)
        begin
            node_addr_reg <= IDX_W'(node_index);
            clr_req_reg   <= clear_after_read;
            oor_reg       <= !in_range;
        end
        if (cmd.scale)
        begin
            base_reg <= base_comb;
            for (int k = 0; k < 4; k++)
            begin
                w_reg[k] <= prod[k][SH+WGT_W-1:SH];
            end
        end
        if (cmd.out_load)
        begin
            node_sum_reg <= oor_reg ? '0 : sum_wide[OUT_SUM_W-1:0];
            sat_reg      <= oor_reg ? 1'b0 : old_flag;
        end
    end

    assign status.clear_last = (clr_cnt_reg == IDX_W'(NODES - 1));
    assign status.out_busy   = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign node_sum  = node_sum_reg;
    assign saturated = sat_reg;

endmodule

// ----- hw/rtl/bilinear_particle_deposit_core.sv -----
// Cloud-in-cell charge deposition onto a GRID_W x GRID_H mesh of saturating
// accumulators held in one memory (one write and one read per cycle). After
// reset the block sweeps the mesh to zero, one node a cycle, and stalls
// requests meanwhile; configuration writes are taken throughout. A deposit
// request is taken in the idle state, which scales the position; the scale
// state forms the cell and the four weights and reads the first corner, then
// each corner in turn is written while the next one is read, so the mesh
// port carries one corner update per cycle. A read request returns its
// result through an output register, waiting only if the previous result is
// still held there; deposits go on while a result waits. Sums saturate at the
// accumulator maximum, which sets the node's sticky flag.
module bilinear_particle_deposit_core #(
    parameter int GRID_W    = bpd_pkg::GRID_W_DEF,
    parameter int GRID_H    = bpd_pkg::GRID_H_DEF,
    parameter int FRAC_BITS = bpd_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = bpd_pkg::ACC_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpd_pkg::CELL_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [bpd_pkg::POS_W-1:0]     pos_x,
    input  logic [bpd_pkg::POS_W-1:0]     pos_y,
    input  logic [bpd_pkg::IDX_IN_W-1:0]  node_index,
    input  logic                          clear_after_read,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bpd_pkg::OUT_SUM_W-1:0] node_sum,
    output logic                          saturated
);
    import bpd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing
    bpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    // mesh, weights and result register
    bpd_dp #(
        .GRID_W    (GRID_W),
        .GRID_H    (GRID_H),
        .FRAC_BITS (FRAC_BITS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .node_index       (node_index),
        .clear_after_read (clear_after_read),
        .cmd              (cmd),
        .status           (status),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .node_sum         (node_sum),
        .saturated        (saturated)
    );

endmodule

// ----- sim/testbench.sv -----
module testbench;

    import bpd_pkg::*;

    localparam int MESH_W    = GRID_W_DEF;
    localparam int MESH_H    = GRID_H_DEF;
    localparam int MESH_N    = MESH_W * MESH_H;
    localparam int ACC_W     = ACC_WIDTH_DEF;
    localparam int W_SHIFT   = 2 * POS_W - FRAC_BITS_DEF;
    localparam int PHASES    = 8;
    localparam int PHASE_REQ = 80;
    localparam int DRAIN_CYC = 16;

    // one read result as the mesh should report it
    typedef struct {
        logic [OUT_SUM_W-1:0] sum;
        logic                 sat;
    } node_report_t;

    // shadow mesh of the deposit core and the reads still owed
    class deposit_scoreboard;
        logic [ACC_W-1:0] mesh_sum [MESH_N];
        bit               mesh_sat [MESH_N];
        logic [CELL_W-1:0] cells_x;
        logic [CELL_W-1:0] cells_y;
        node_report_t     owed_reads [$];
        int               errors;

        function new();
            foreach (mesh_sum[n])
            begin
                mesh_sum[n] = '0;
                mesh_sat[n] = 1'b0;
            end
            cells_x = CELLS_RESET;
            cells_y = CELLS_RESET;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CELL_W-1:0] value);
            if (idx == REG_CELLS_ACROSS)
                cells_x = value;
            else if (idx == REG_CELLS_DOWN)
                cells_y = value;
        endfunction

        // cell count in use: zero acts as one, capped at one fewer than the mesh nodes per side
        function int span(logic [CELL_W-1:0] c, int limit);
            int n;
            n = int'(c);
            if (n == 0)
                n = 1;
            if (n > limit)
                n = limit;
            return n;
        endfunction

        // saturating add of one corner weight
        function void add_weight(int idx, logic [63:0] w);
            logic [63:0] s;
            logic [63:0] top;
            if (idx >= MESH_N)
                return;
            top = {{(64-ACC_W){1'b0}}, {ACC_W{1'b1}}};
            s   = {{(64-ACC_W){1'b0}}, mesh_sum[idx]};
            if (s > top - w)
                s = top;
            else
                s = s + w;
            if (s == top)
                mesh_sat[idx] = 1'b1;
            mesh_sum[idx] = s[ACC_W-1:0];
        endfunction

        function void deposit(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
            int          cx;
            int          cy;
            int          i;
            int          j;
            int          base;
            logic [31:0] sx;
            logic [31:0] sy;
            logic [63:0] hx;
            logic [63:0] hy;
            logic [63:0] gx;
            logic [63:0] gy;
            cx = span(cells_x, MESH_W - 1);
            cy = span(cells_y, MESH_H - 1);
            sx = 32'(px) * 32'(cx);
            sy = 32'(py) * 32'(cy);
            i  = int'(sx[31:16]);
            j  = int'(sy[31:16]);
            hx = {48'd0, sx[15:0]};
            hy = {48'd0, sy[15:0]};
            gx = 64'd65536 - hx;
            gy = 64'd65536 - hy;
            if (i > cx - 1)
                i = cx - 1;
            if (j > cy - 1)
                j = cy - 1;
            base = j * MESH_W + i;
            add_weight(base,              (gx * gy) >> W_SHIFT);
            add_weight(base + 1,          (hx * gy) >> W_SHIFT);
            add_weight(base + MESH_W,     (gx * hy) >> W_SHIFT);
            add_weight(base + MESH_W + 1, (hx * hy) >> W_SHIFT);
        endfunction

        // accepted request: update the shadow mesh, queue what a read returns
        function void note_request(logic act, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                   logic [IDX_IN_W-1:0] idx, logic clr);
            node_report_t r;
            if (act == ACT_DEPOSIT)
            begin
                deposit(px, py);
                return;
            end
            if (idx >= MESH_N)
            begin
                r.sum = '0;
                r.sat = 1'b0;
            end
            else
            begin
                r.sum = mesh_sum[idx];
                r.sat = mesh_sat[idx];
                if (clr)
                begin
                    mesh_sum[idx] = '0;
                    mesh_sat[idx] = 1'b0;
                end
            end
            owed_reads.push_back(r);
        endfunction

        function void check_result(logic [OUT_SUM_W-1:0] sum, logic sat);
            node_report_t r;
            if (owed_reads.size() == 0)
            begin
                $display("%0t: result with no read pending: sum %h sat %b", $time, sum, sat);
                errors++;
                return;
            end
            r = owed_reads.pop_front();
            if (sum !== r.sum)
            begin
                $display("%0t: node_sum expected %h actual %h", $time, r.sum, sum);
                errors++;
            end
            if (sat !== r.sat)
            begin
                $display("%0t: saturated expected %b actual %b", $time, r.sat, sat);
                errors++;
            end
        endfunction

        function int pending();
            return owed_reads.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CELL_W-1:0]     cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  action;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [IDX_IN_W-1:0]   node_index;
    logic                  clear_after_read;
    logic                  out_valid;
    logic                  out_stall;
    logic [OUT_SUM_W-1:0]  node_sum;
    logic                  saturated;

    deposit_scoreboard sb = new();
    int                burst_left = 0;

    bilinear_particle_deposit_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .node_index       (node_index),
        .clear_after_read (clear_after_read),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .node_sum         (node_sum),
        .saturated        (saturated)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // write both cell counts, one register per cycle
    task automatic write_cells(input logic [CELL_W-1:0] across, input logic [CELL_W-1:0] down);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_CELLS_ACROSS;
        cfg_data  <= across;
        @(posedge clk);
        sb.write_reg(REG_CELLS_ACROSS, across);
        cfg_index <= REG_CELLS_DOWN;
        cfg_data  <= down;
        @(posedge clk);
        sb.write_reg(REG_CELLS_DOWN, down);
        cfg_wr_en <= 1'b0;
    endtask

    // offer one request, hold it until taken, then maybe pause between bursts
    task automatic send_request(input logic act, input logic [POS_W-1:0] px,
                                input logic [POS_W-1:0] py, input logic [IDX_IN_W-1:0] idx,
                                input logic clr);
        int gap;
        in_valid         <= 1'b1;
        action           <= act;
        pos_x            <= px;
        pos_y            <= py;
        node_index       <= idx;
        clear_after_read <= clr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(act, px, py, idx, clr);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic deposit_at(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
        send_request(ACT_DEPOSIT, px, py, IDX_IN_W'($urandom), 1'($urandom));
    endtask

    task automatic read_node(input int idx, input logic clr);
        send_request(ACT_READ, POS_W'($urandom), POS_W'($urandom), IDX_IN_W'(idx), clr);
    endtask

    // random mix: deposits, reads mostly inside the active cells
    task automatic random_request();
        int          cx;
        int          cy;
        int          pick;
        logic [15:0] px;
        logic [15:0] py;
        cx   = sb.span(sb.cells_x, MESH_W - 1);
        cy   = sb.span(sb.cells_y, MESH_H - 1);
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            px = POS_W'($urandom);
            py = POS_W'($urandom);
            if ($urandom_range(0, 7) == 0)
                px = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            if ($urandom_range(0, 7) == 0)
                py = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            deposit_at(px, py);
        end
        else if (pick < 88)
            read_node($urandom_range(0, cy) * MESH_W + $urandom_range(0, cx),
                      ($urandom_range(0, 2) == 0));
        else
            read_node($urandom_range(0, MESH_N - 1), 1'($urandom));
    endtask

    // wait for every read to come back, then for a deposit still in flight
    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // result side: check, stall on its own pattern, two long hold-offs
    initial
    begin : result_sink
        int  mode;
        int  mode_left;
        int  hold_left;
        int  results_seen;
        int  next_hold;
        bit  toggle;
        logic stall_next;
        mode         = 0;
        mode_left    = 0;
        hold_left    = 0;
        results_seen = 0;
        next_hold    = 40;
        toggle       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                sb.check_result(node_sum, saturated);
                results_seen++;
            end
            if (hold_left == 0 && results_seen >= next_hold)
            begin
                hold_left = 400;
                next_hold = (next_hold < 200) ? 220 : 1 << 30;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 96);
            end
            mode_left--;
            toggle = !toggle;
            case (mode)
                0: stall_next = 1'b0;
                1: stall_next = ($urandom_range(0, 3) == 0);
                2: stall_next = ($urandom_range(0, 3) != 0);
                default: stall_next = toggle;
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            out_stall <= stall_next;
        end
    end

    // stimulus
    initial
    begin : stimulus
        int          p;
        int          k;
        logic [5:0]  across_set [PHASES];
        logic [5:0]  down_set [PHASES];
        across_set = '{6'd63, 6'd0, 6'd1, 6'd1, 6'd63, 6'd2, 6'd0, 6'd0};
        down_set   = '{6'd63, 6'd0, 6'd1, 6'd63, 6'd1, 6'd3, 6'd0, 6'd0};
        across_set[6] = 6'($urandom_range(1, 63));
        down_set[6]   = 6'($urandom_range(1, 63));
        across_set[7] = 6'($urandom_range(0, 63));
        down_set[7]   = 6'($urandom_range(0, 63));

        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_index        <= REG_CELLS_ACROSS;
        cfg_data         <= '0;
        in_valid         <= 1'b0;
        action           <= ACT_DEPOSIT;
        pos_x            <= '0;
        pos_y            <= '0;
        node_index       <= '0;
        clear_after_read <= 1'b0;
        out_stall        <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < PHASES; p++)
        begin
            write_cells(across_set[p], down_set[p]);

            // directed corners and clears on the full mesh
            if (p == 0)
            begin
                deposit_at(16'h0000, 16'h0000);
                deposit_at(16'hFFFF, 16'hFFFF);
                deposit_at(16'h8000, 16'h0000);
                deposit_at(16'h0000, 16'hFFFF);
                deposit_at(16'hFFFF, 16'h0000);
                deposit_at(16'h0001, 16'h7FFF);
                read_node(0, 1'b0);
                read_node(0, 1'b1);
                read_node(0, 1'b0);
                read_node(1, 1'b0);
                read_node(MESH_W, 1'b0);
                read_node(MESH_W + 1, 1'b1);
                read_node(MESH_N - 1, 1'b1);
                read_node(MESH_N - 1, 1'b0);
                read_node(MESH_N - 2, 1'b0);
                read_node(MESH_N - MESH_W, 1'b0);
                read_node(MESH_W - 1, 1'b0);
                read_node(MESH_N / 2 + 17, 1'b1);
            end

            // zero cell count acts as one cell
            if (p == 1)
            begin
                deposit_at(16'hFFFF, 16'hFFFF);
                deposit_at(16'h0000, 16'h0000);
                read_node(MESH_W + 1, 1'b1);
                read_node(0, 1'b0);
            end

            for (k = 0; k < PHASE_REQ; k++)
                random_request();
            drain();
        end

        if (sb.errors == 0)
            $display("PASS bilinear_particle_deposit_core");
        else
            $display("FAIL bilinear_particle_deposit_core");
        $finish;
    end

    // run limit
    initial
    begin : watchdog
        #(20 * 400000);
        $display("FAIL bilinear_particle_deposit_core");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/bpd_pkg.sv
hw/rtl/bpd_ctrl.sv
hw/rtl/bpd_dp.sv
hw/rtl/bilinear_particle_deposit_core.sv
sim/testbench.sv
